@@ rtl/ima_pkg.sv @@
// Shared types, command codes and the step table for the IMA ADPCM block decoder.
`default_nettype none
package ima_pkg;

  localparam int STEP_MAX = 88;

  localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

  // Header position codes
  localparam logic [2:0] HDR_LO   = 3'd0;
  localparam logic [2:0] HDR_HI   = 3'd1;
  localparam logic [2:0] HDR_STEP = 3'd2;
  localparam logic [2:0] HDR_PAD  = 3'd3;
  localparam logic [2:0] HDR_DATA = 3'd4;

  // Command codes from front to back
  localparam logic [1:0] CMD_PRED = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_EMIT = 2'd2;
  localparam logic [1:0] CMD_DEC  = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] data;  // predictor, step index or packed byte, low-aligned
    logic        two;   // decode both nibbles
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  localparam logic [14:0] STEP_TABLE [0:88] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086,
    15'd29794, 15'd32767
  };

  localparam logic signed [4:0] INDEX_ADJ [0:7] = '{
    -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
  };

endpackage
`default_nettype wire

@@ rtl/ima_front.sv @@
// Front end: parses header bytes, tracks the sample budget and issues commands.
`default_nettype none
module ima_front #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [15:0]  cfg_wdata,
  input  wire logic         in_valid,
  input  wire logic         in_stall,
  input  wire logic [7:0]   in_data_byte,
  input  wire logic         in_block_start,
  output ima_pkg::cmd_t     push_cmd,
  output logic              push
);

  localparam int CMPW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic [15:0]            limit_r;
  logic [2:0]             hdr_pos_r, hdr_pos_nxt;
  logic [7:0]             low_byte_r, low_byte_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] cnt_inc1, cnt_inc2;
  logic [CMPW-1:0]        lim_ext, cnt0_ext, cnt1_ext;
  logic                   full0, full1;
  logic [2:0]             pos;
  logic                   accept;

  assign accept   = in_valid && !in_stall;
  assign pos      = in_block_start ? ima_pkg::HDR_LO : hdr_pos_r;
  assign cnt_inc1 = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
  assign cnt_inc2 = (cnt_inc1 == '1) ? cnt_inc1 : cnt_inc1 + 1'b1;
  assign lim_ext  = CMPW'(limit_r);
  assign cnt0_ext = CMPW'(cnt_r);
  assign cnt1_ext = CMPW'(cnt_inc1);
  assign full0    = cnt0_ext >= lim_ext;
  assign full1    = cnt1_ext >= lim_ext;

  always_comb begin
    hdr_pos_nxt   = hdr_pos_r;
    low_byte_nxt  = low_byte_r;
    cnt_nxt       = cnt_r;
    push          = 1'b0;
    push_cmd.op   = ima_pkg::CMD_DEC;
    push_cmd.data = {8'd0, in_data_byte};
    push_cmd.two  = 1'b0;
    if (accept) begin
      case (pos)
        ima_pkg::HDR_LO: begin
          low_byte_nxt = in_data_byte;
          cnt_nxt      = '0;
          hdr_pos_nxt  = ima_pkg::HDR_HI;
        end
        ima_pkg::HDR_HI: begin
          push          = 1'b1;
          push_cmd.op   = ima_pkg::CMD_PRED;
          push_cmd.data = {in_data_byte, low_byte_r};
          hdr_pos_nxt   = ima_pkg::HDR_STEP;
        end
        ima_pkg::HDR_STEP: begin
          push        = 1'b1;
          push_cmd.op = ima_pkg::CMD_STEP;
          // clamp the step index to the table
          if (in_data_byte > 8'(ima_pkg::STEP_MAX)) begin
            push_cmd.data = 16'(ima_pkg::STEP_MAX);
          end
          hdr_pos_nxt = ima_pkg::HDR_PAD;
        end
        ima_pkg::HDR_PAD: begin
          hdr_pos_nxt = ima_pkg::HDR_DATA;
          if (!full0) begin
            push        = 1'b1;
            push_cmd.op = ima_pkg::CMD_EMIT;
            cnt_nxt     = cnt_inc1;
          end
        end
        default: begin
          hdr_pos_nxt = ima_pkg::HDR_DATA;
          // drop the byte once the budget is spent
          if (!full0) begin
            push         = 1'b1;
            push_cmd.op  = ima_pkg::CMD_DEC;
            push_cmd.two = !full1;
            cnt_nxt      = full1 ? cnt_inc1 : cnt_inc2;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= ima_pkg::LIMIT_RESET;
      hdr_pos_r  <= ima_pkg::HDR_LO;
      low_byte_r <= 8'd0;
      cnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      hdr_pos_r  <= hdr_pos_nxt;
      low_byte_r <= low_byte_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ima_queue.sv @@
// Two-entry command queue between the front and back ends.
`default_nettype none
module ima_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ima_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output ima_pkg::head_t     head,
  output logic               full
);

  ima_pkg::cmd_t mem_r [0:1];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;

  assign full       = cnt_r == 2'd2;
  assign head.valid = cnt_r != 2'd0;
  assign head.cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count out of range");

endmodule
`default_nettype wire

@@ rtl/ima_back.sv @@
// Back end: holds predictor and step index, decodes one nibble per cycle while the output is not stalled.
`default_nettype none
module ima_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ima_pkg::head_t head,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic signed [15:0]  out_sample,
  output logic                out_last_of_item
);

  logic signed [15:0] pred_r;
  logic [6:0]         step_r;
  logic               half_r;
  logic               out_valid_r;
  logic signed [15:0] sample_r;
  logic               last_r;

  logic               can_go;
  logic [3:0]         code;
  logic [14:0]        step_size;
  logic [16:0]        diff;
  logic signed [17:0] sum;
  logic signed [15:0] sat;
  logic signed [8:0]  idx_sum;
  logic [6:0]         idx_nxt;
  logic               is_last;
  logic               fire;

  assign can_go    = !out_valid_r || !out_stall;
  assign code      = half_r ? head.cmd.data[7:4] : head.cmd.data[3:0];
  assign step_size = ima_pkg::STEP_TABLE[step_r];
  assign is_last   = half_r || !head.cmd.two;

  always_comb begin
    diff = 17'(step_size >> 3);
    if (code[0]) diff = diff + 17'(step_size >> 2);
    if (code[1]) diff = diff + 17'(step_size >> 1);
    if (code[2]) diff = diff + 17'(step_size);
    if (code[3]) begin
      sum = 18'(pred_r) - $signed({1'b0, diff});
    end else begin
      sum = 18'(pred_r) + $signed({1'b0, diff});
    end
    if (sum > 18'sd32767) begin
      sat = 16'sh7FFF;
    end else if (sum < -18'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = sum[15:0];
    end
    idx_sum = $signed({2'b00, step_r}) + 9'(ima_pkg::INDEX_ADJ[code[2:0]]);
    if (idx_sum < 9'sd0) begin
      idx_nxt = 7'd0;
    end else if (idx_sum > 9'(ima_pkg::STEP_MAX)) begin
      idx_nxt = 7'(ima_pkg::STEP_MAX);
    end else begin
      idx_nxt = idx_sum[6:0];
    end
  end

  always_comb begin
    pop  = 1'b0;
    fire = 1'b0;
    if (head.valid) begin
      case (head.cmd.op)
        ima_pkg::CMD_PRED: pop = 1'b1;
        ima_pkg::CMD_STEP: pop = 1'b1;
        ima_pkg::CMD_EMIT: begin
          fire = can_go;
          pop  = can_go;
        end
        ima_pkg::CMD_DEC: begin
          fire = can_go;
          pop  = can_go && is_last;
        end
        default: pop = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (head.cmd.op == ima_pkg::CMD_EMIT) begin
        sample_r <= pred_r;
        last_r   <= 1'b1;
      end else begin
        sample_r <= sat;
        last_r   <= is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_r      <= 16'sd0;
      step_r      <= 7'd0;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (head.valid) begin
        case (head.cmd.op)
          ima_pkg::CMD_PRED: pred_r <= head.cmd.data;
          ima_pkg::CMD_STEP: step_r <= head.cmd.data[6:0];
          ima_pkg::CMD_DEC: begin
            if (fire) begin
              pred_r <= sat;
              step_r <= idx_nxt;
              half_r <= !is_last;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = sample_r;
  assign out_last_of_item = last_r;

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= 7'(ima_pkg::STEP_MAX)) else $error("step index past table end");
  a_half_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> (head.valid && head.cmd.op == ima_pkg::CMD_DEC && head.cmd.two))
    else $error("high nibble pending without a two-nibble command");
  a_half_set: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && head.cmd.op == ima_pkg::CMD_DEC && head.cmd.two && !half_r) |=> half_r)
    else $error("high nibble not scheduled after low nibble");

endmodule
`default_nettype wire

@@ rtl/ima_adpcm_block_decoder_unit.sv @@
// Top level of the byte-serial IMA ADPCM block decoder.
//
//  channel  | ports                                      | direction
//  ---------+--------------------------------------------+----------
//  input    | in_valid, in_stall, in_data_byte,          | in
//           | in_block_start                             |
//  result   | out_valid, out_stall, out_sample,          | out
//           | out_last_of_item                           |
//  config   | cfg_we, cfg_wdata (sample_limit)           | in
//
// In the back end a data byte goes through the step table and saturating adder one
// nibble per cycle while not stalled; header bytes issue one command or none.
// A two-entry command queue separates byte parsing from decoding.
// Reset is synchronous, active low; sample_limit resets to 65535.
// in_stall rises only when the command queue is full; the result register
// accepts a new sample in the same cycle the held one transfers.
`default_nettype none
module ima_adpcm_block_decoder_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_block_start,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_sample,
  output logic                    out_last_of_item
);

  ima_pkg::cmd_t  push_cmd;
  ima_pkg::head_t head;
  logic           push;
  logic           pop;
  logic           full;

  assign in_stall = full;

  ima_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (full),
    .in_data_byte  (in_data_byte),
    .in_block_start(in_block_start),
    .push_cmd      (push_cmd),
    .push          (push)
  );

  ima_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .full    (full)
  );

  ima_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample      (out_sample),
    .out_last_of_item(out_last_of_item)
  );

endmodule
`default_nettype wire
